@@ rtl/core/assert_macros.svh @@
// Assertion helpers: clocked, disabled while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent on the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/swq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package swq_pkg;

  localparam int NumProcsDef = 32;
  localparam int KeyW        = 32;
  localparam int PidW        = 5;

  localparam logic [1:0] FN_BLOCK   = 2'd0;
  localparam logic [1:0] FN_UNBLOCK = 2'd1;
  localparam logic [1:0] FN_REMOVE  = 2'd2;
  localparam logic [1:0] FN_PEEK    = 2'd3;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_MISS   = 2'd2;

  typedef struct packed {
    logic [1:0]      func;
    logic [KeyW-1:0] sem_key;
    logic [PidW-1:0] proc_id;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [PidW-1:0] proc_out;
  } rsp_t;

endpackage
`default_nettype wire

@@ rtl/core/swq_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface swq_req_if import swq_pkg::*;;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface swq_rsp_if import swq_pkg::*;;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/swq_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Simple dual-port RAM, registered read.
module swq_ram #(
  parameter int Width = 8,
  parameter int Depth = 32,
  parameter int AddrW = 5
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/semaphore_wait_queue_table_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Active semaphore table: up to NUM_PROCS descriptors, each keyed by a 32-bit
// semaphore address and holding a FIFO of blocked process ids as a linked
// list. One request at a time; one response per request, held in an output
// register until taken. Block, unblock-head and peek-head search the table in
// index order. Remove finds the descriptor through the slot memory and walks
// the link memory from the head, one read per cycle, to the entry ahead of
// the process. No clearing pass after reset.
module semaphore_wait_queue_table_core import swq_pkg::*; #(
  parameter int NUM_PROCS = NumProcsDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  swq_req_if.sink    req_i,
  swq_rsp_if.source  rsp_o
);

  localparam int IW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int DW = KeyW + 2 * IW;  // descriptor word: key, first, last
  localparam logic [IW-1:0] LastIx = IW'(NUM_PROCS - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;  // pick next descriptor
  localparam logic [3:0] S_SCMP = 4'd2;  // compare its key
  localparam logic [3:0] S_POP  = 4'd3;  // link of popped head is back
  localparam logic [3:0] S_SLOT = 4'd4;  // slot of process is back
  localparam logic [3:0] S_DRD  = 4'd5;  // descriptor of slot is back
  localparam logic [3:0] S_WALK = 4'd6;  // walking the queue
  localparam logic [3:0] S_UNL  = 4'd7;  // link of removed process is back

  logic [3:0]      state_q, state_d;
  logic [1:0]      func_q, func_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [IW-1:0]   pid_q, pid_d;
  logic [IW-1:0]   cnt_q, cnt_d;
  logic [IW-1:0]   dix_q, dix_d;
  logic [KeyW-1:0] rkey_q, rkey_d;
  logic [IW-1:0]   first_q, first_d;
  logic [IW-1:0]   last_q, last_d;
  logic [IW-1:0]   prev_q, prev_d;
  logic            free_v_q, free_v_d;
  logic [IW-1:0]   free_q, free_d;
  logic [NUM_PROCS-1:0] in_use_q, in_use_d;
  logic [NUM_PROCS-1:0] wait_q, wait_d;
  logic            out_v_q, out_v_d;
  logic [1:0]      status_q, status_d;
  logic [PidW-1:0] pout_q, pout_d;

  // memory ports
  logic            d_we, d_re, l_we, l_re, s_we, s_re;
  logic [IW-1:0]   d_waddr, d_raddr, l_waddr, l_raddr, s_waddr, s_raddr;
  logic [DW-1:0]   d_wdata, d_rdata;
  logic [IW-1:0]   l_wdata, l_rdata, s_wdata, s_rdata;

  logic [KeyW-1:0] rd_key;
  logic [IW-1:0]   rd_first, rd_last;
  logic            accept;

  assign rd_key   = d_rdata[DW-1 -: KeyW];
  assign rd_first = d_rdata[2*IW-1 -: IW];
  assign rd_last  = d_rdata[IW-1:0];

  assign req_i.ready       = (state_q == S_IDLE) && !out_v_q;
  assign accept            = req_i.valid && req_i.ready;
  assign rsp_o.valid       = out_v_q;
  assign rsp_o.data.status   = status_q;
  assign rsp_o.data.proc_out = pout_q;

  swq_ram #(.Width(DW), .Depth(NUM_PROCS), .AddrW(IW)) u_desc (
    .clk_i, .we_i(d_we), .waddr_i(d_waddr), .wdata_i(d_wdata),
    .re_i(d_re), .raddr_i(d_raddr), .rdata_o(d_rdata)
  );
  swq_ram #(.Width(IW), .Depth(NUM_PROCS), .AddrW(IW)) u_link (
    .clk_i, .we_i(l_we), .waddr_i(l_waddr), .wdata_i(l_wdata),
    .re_i(l_re), .raddr_i(l_raddr), .rdata_o(l_rdata)
  );
  swq_ram #(.Width(IW), .Depth(NUM_PROCS), .AddrW(IW)) u_slot (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .re_i(s_re), .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  always_comb begin
    logic          pid_ok;
    logic [IW-1:0] pid_c;
    logic          fv_c;
    logic [IW-1:0] fi_c;
    logic          miss;
    logic          pop;
    logic [IW-1:0] p_d, p_f, p_l;
    logic [KeyW-1:0] p_k;

    state_d  = state_q;  func_d = func_q;  key_d = key_q;  pid_d = pid_q;
    cnt_d    = cnt_q;    dix_d  = dix_q;   rkey_d = rkey_q;
    first_d  = first_q;  last_d = last_q;  prev_d = prev_q;
    in_use_d = in_use_q; wait_d = wait_q;
    out_v_d  = out_v_q;  status_d = status_q; pout_d = pout_q;
    d_we = 1'b0; d_re = 1'b0; l_we = 1'b0; l_re = 1'b0; s_we = 1'b0; s_re = 1'b0;
    d_waddr = dix_q; d_raddr = cnt_q; d_wdata = {rkey_q, first_q, last_q};
    l_waddr = prev_q; l_raddr = prev_q; l_wdata = pid_q;
    s_waddr = pid_q; s_raddr = pid_q; s_wdata = cnt_q;
    miss = 1'b0; pop = 1'b0;
    p_d = cnt_q; p_f = rd_first; p_l = rd_last; p_k = rd_key;

    pid_ok = 32'(req_i.data.proc_id) < 32'(NUM_PROCS);
    pid_c  = IW'(req_i.data.proc_id);

    // lowest free descriptor seen during the scan
    fv_c = free_v_q;
    fi_c = free_q;
    if ((state_q == S_SCAN) && !in_use_q[cnt_q] && !free_v_q) begin
      fv_c = 1'b1;
      fi_c = cnt_q;
    end
    free_v_d = fv_c;
    free_d   = fi_c;

    if (rsp_o.ready && out_v_q) begin
      out_v_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          func_d   = req_i.data.func;
          key_d    = req_i.data.sem_key;
          pid_d    = pid_c;
          cnt_d    = '0;
          free_v_d = 1'b0;
          status_d = ST_DONE;
          pout_d   = '0;
          if (req_i.data.func == FN_BLOCK) begin
            if (!pid_ok || wait_q[pid_c]) begin
              out_v_d  = 1'b1;
              status_d = ST_REJECT;
            end else begin
              state_d = S_SCAN;
            end
          end else if (req_i.data.func == FN_REMOVE) begin
            if (!pid_ok || !wait_q[pid_c]) begin
              out_v_d  = 1'b1;
              status_d = ST_MISS;
            end else begin
              s_re    = 1'b1;
              s_raddr = pid_c;
              state_d = S_SLOT;
            end
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (in_use_q[cnt_q]) begin
          d_re    = 1'b1;
          d_raddr = cnt_q;
          state_d = S_SCMP;
        end else if (cnt_q == LastIx) begin
          miss = 1'b1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_SCMP: begin
        if (rd_key == key_q) begin
          if (func_q == FN_BLOCK) begin
            // append behind current tail
            l_we    = 1'b1;
            l_waddr = rd_last;
            l_wdata = pid_q;
            d_we    = 1'b1;
            d_waddr = cnt_q;
            d_wdata = {rd_key, rd_first, pid_q};
            s_we    = 1'b1;
            s_waddr = pid_q;
            s_wdata = cnt_q;
            wait_d[pid_q] = 1'b1;
            out_v_d = 1'b1;
            state_d = S_IDLE;
          end else if (func_q == FN_PEEK) begin
            pout_d  = PidW'(rd_first);
            out_v_d = 1'b1;
            state_d = S_IDLE;
          end else begin
            pop = 1'b1;
          end
        end else if (cnt_q == LastIx) begin
          miss = 1'b1;
          state_d = S_IDLE;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_SCAN;
        end
      end
      S_POP: begin
        // new head is the popped process's successor
        d_we    = 1'b1;
        d_waddr = dix_q;
        d_wdata = {rkey_q, l_rdata, last_q};
        pout_d  = PidW'(first_q);
        out_v_d = 1'b1;
        state_d = S_IDLE;
      end
      S_SLOT: begin
        dix_d   = s_rdata;
        d_re    = 1'b1;
        d_raddr = s_rdata;
        state_d = S_DRD;
      end
      S_DRD: begin
        if (rd_first == pid_q) begin
          pop = 1'b1;
          p_d = dix_q;
        end else begin
          rkey_d  = rd_key;
          first_d = rd_first;
          last_d  = rd_last;
          prev_d  = rd_first;
          l_re    = 1'b1;
          l_raddr = rd_first;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        l_re = 1'b1;
        if (l_rdata == pid_q) begin
          l_raddr = pid_q;
          state_d = S_UNL;
        end else begin
          prev_d  = l_rdata;
          l_raddr = l_rdata;
        end
      end
      S_UNL: begin
        l_we    = 1'b1;
        l_waddr = prev_q;
        l_wdata = l_rdata;
        if (last_q == pid_q) begin
          d_we    = 1'b1;
          d_waddr = dix_q;
          d_wdata = {rkey_q, first_q, prev_q};
        end
        wait_d[pid_q] = 1'b0;
        pout_d  = PidW'(pid_q);
        out_v_d = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // key not active
    if (miss) begin
      state_d = S_IDLE;
      out_v_d = 1'b1;
      if (func_q == FN_BLOCK) begin
        if (fv_c) begin
          d_we    = 1'b1;
          d_waddr = fi_c;
          d_wdata = {key_q, pid_q, pid_q};
          s_we    = 1'b1;
          s_waddr = pid_q;
          s_wdata = fi_c;
          in_use_d[fi_c] = 1'b1;
          wait_d[pid_q]  = 1'b1;
        end else begin
          status_d = ST_REJECT;
        end
      end else begin
        status_d = ST_MISS;
      end
    end

    // pop head of descriptor p_d; frees it when the queue empties
    if (pop) begin
      wait_d[p_f] = 1'b0;
      dix_d   = p_d;
      rkey_d  = p_k;
      first_d = p_f;
      last_d  = p_l;
      if (p_f == p_l) begin
        in_use_d[p_d] = 1'b0;
        pout_d  = PidW'(p_f);
        out_v_d = 1'b1;
        state_d = S_IDLE;
      end else begin
        l_re    = 1'b1;
        l_raddr = p_f;
        state_d = S_POP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      in_use_q <= '0;
      wait_q   <= '0;
      out_v_q  <= 1'b0;
      free_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      in_use_q <= in_use_d;
      wait_q   <= wait_d;
      out_v_q  <= out_v_d;
      free_v_q <= free_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    key_q    <= key_d;
    pid_q    <= pid_d;
    cnt_q    <= cnt_d;
    dix_q    <= dix_d;
    rkey_q   <= rkey_d;
    first_q  <= first_d;
    last_q   <= last_d;
    prev_q   <= prev_d;
    free_q   <= free_d;
    status_q <= status_d;
    pout_q   <= pout_d;
  end

`include "assert_macros.svh"

  // an active descriptor always has at least one waiter
  `ASSERT_ALWAYS(a_no_empty_desc, clk_i, rst_ni, $countones(in_use_q) <= $countones(wait_q), "active descriptor without waiter")
  // failed requests report no process
  `ASSERT_ALWAYS(a_pout_zero, clk_i, rst_ni, !out_v_q || status_q == ST_DONE || pout_q == '0, "proc_out set on failure")
  // an accepted request is either being worked on or answered
  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, out_v_q || state_q != S_IDLE, "request dropped")

endmodule
`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Checks the semaphore wait queue table against its own table model. Every
// operation runs with random key and process mixes. Both sides idle at
// random, and the response side is at times held off for a long stretch.
module tb;
  import swq_pkg::*;

  localparam int NPROC     = NumProcsDef;
  localparam int IDLE_MAX  = 13;
  localparam int HOLD_LEN  = 300;
  localparam int WDOG_LIM  = 5000;
  localparam int N_RANDOM  = 1150;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  swq_req_if req_if ();
  swq_rsp_if rsp_if ();

  semaphore_wait_queue_table_core #(.NUM_PROCS(NPROC)) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Shadow copy of the semaphore table.
  logic [KeyW-1:0] sh_key   [NPROC];
  bit              sh_used  [NPROC];
  logic [PidW-1:0] sh_first [NPROC];
  logic [PidW-1:0] sh_last  [NPROC];
  logic [PidW-1:0] sh_link  [NPROC];
  bit              sh_wait  [NPROC];
  logic [PidW-1:0] sh_slot  [NPROC];

  rsp_t         pending_rsp[$];
  int           n_errors;
  bit           hold_rsp;
  bit           send_burst;
  logic [31:0]  key_pool[8];

  function automatic int find_slot(logic [KeyW-1:0] key);
    for (int d = 0; d < NPROC; d++) begin
      if (sh_used[d] && sh_key[d] == key) return d;
    end
    return -1;
  endfunction

  // Pop the head of a queue; the descriptor is freed when the queue empties.
  function automatic logic [PidW-1:0] pop_first(int d);
    logic [PidW-1:0] p;
    p = sh_first[d];
    sh_wait[p] = 1'b0;
    if (p == sh_last[d]) sh_used[d] = 1'b0;
    else sh_first[d] = sh_link[p];
    return p;
  endfunction

  function automatic rsp_t apply_request(req_t rq);
    rsp_t rs;
    int   d;
    int   prev;
    rs = '0;
    rs.status = ST_DONE;
    case (rq.func)
      FN_BLOCK: begin
        if (sh_wait[rq.proc_id]) begin
          rs.status = ST_REJECT;
        end else begin
          d = find_slot(rq.sem_key);
          if (d >= 0) begin
            sh_link[sh_last[d]] = rq.proc_id;
            sh_last[d] = rq.proc_id;
          end else begin
            for (int f = 0; f < NPROC; f++) begin
              if (!sh_used[f]) begin
                d = f;
                break;
              end
            end
            if (d >= 0) begin
              sh_used[d]  = 1'b1;
              sh_key[d]   = rq.sem_key;
              sh_first[d] = rq.proc_id;
              sh_last[d]  = rq.proc_id;
            end
          end
          if (d >= 0) begin
            sh_wait[rq.proc_id] = 1'b1;
            sh_slot[rq.proc_id] = PidW'(d);
          end else begin
            rs.status = ST_REJECT;
          end
        end
      end
      FN_UNBLOCK, FN_PEEK: begin
        d = find_slot(rq.sem_key);
        if (d < 0) rs.status = ST_MISS;
        else if (rq.func == FN_UNBLOCK) rs.proc_out = pop_first(d);
        else rs.proc_out = sh_first[d];
      end
      default: begin
        if (!sh_wait[rq.proc_id]) begin
          rs.status = ST_MISS;
        end else begin
          d = sh_slot[rq.proc_id];
          if (sh_first[d] == rq.proc_id) begin
            rs.proc_out = pop_first(d);
          end else begin
            // walk the chain to the entry ahead of the process
            prev = sh_first[d];
            while (sh_link[prev] != rq.proc_id) prev = sh_link[prev];
            sh_link[prev] = sh_link[rq.proc_id];
            if (sh_last[d] == rq.proc_id) sh_last[d] = PidW'(prev);
            sh_wait[rq.proc_id] = 1'b0;
            rs.proc_out = rq.proc_id;
          end
        end
      end
    endcase
    return rs;
  endfunction

  // Send one request, after a random idle gap unless in a burst; predict once it is taken.
  task automatic send_req(logic [1:0] fn, logic [KeyW-1:0] key, logic [PidW-1:0] pid);
    int   gap;
    req_t rq;
    gap = send_burst ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rq.func = fn;
    rq.sem_key = key;
    rq.proc_id = pid;
    req_if.valid <= 1'b1;
    req_if.data  <= rq;
    do @(posedge clk_i); while (!req_if.ready);
    pending_rsp.push_back(apply_request(rq));
  endtask

  task automatic wait_drain();
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // Response side: random stall per response, long hold when asked.
  initial begin
    int n;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
        hold_rsp = 1'b0;
      end
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IDLE_MAX);
      if (n > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  // Compare each taken response with the oldest prediction.
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response status=%0d proc=%0d", $time,
                 rsp_if.data.status, rsp_if.data.proc_out);
        n_errors++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (rsp_if.data.status !== exp_rsp.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_rsp.status, rsp_if.data.status);
          n_errors++;
        end
        if (rsp_if.data.proc_out !== exp_rsp.proc_out) begin
          $display("%0t: proc_out expected %0d actual %0d", $time,
                   exp_rsp.proc_out, rsp_if.data.proc_out);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: too long without any handshake ends the run.
  always @(posedge clk_i) begin
    int idle_cnt;
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cnt = 0;
    end else if (rst_ni) begin
      idle_cnt++;
      if (idle_cnt >= WDOG_LIM) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Misses on an empty table, rejects, middle and tail removal, key extremes.
  task automatic test_basic_ops();
    send_req(FN_PEEK, 32'h0, 5'd0);
    send_req(FN_UNBLOCK, 32'hFFFF_FFFF, 5'd0);
    send_req(FN_REMOVE, 32'h0, 5'd31);
    send_req(FN_BLOCK, 32'h0, 5'd0);
    send_req(FN_BLOCK, 32'hFFFF_FFFF, 5'd31);
    send_req(FN_BLOCK, 32'h1234_5678, 5'd0);
    send_req(FN_PEEK, 32'h0, 5'd9);
    send_req(FN_BLOCK, 32'h0, 5'd5);
    send_req(FN_BLOCK, 32'h0, 5'd7);
    send_req(FN_BLOCK, 32'h0, 5'd10);
    send_req(FN_REMOVE, 32'hFFFF_FFFF, 5'd5);
    send_req(FN_REMOVE, 32'h0, 5'd10);
    send_req(FN_UNBLOCK, 32'h0, 5'd3);
    send_req(FN_PEEK, 32'h0, 5'd3);
    send_req(FN_UNBLOCK, 32'h0, 5'd3);
    send_req(FN_PEEK, 32'h0, 5'd3);
    send_req(FN_PEEK, 32'hFFFF_FFFF, 5'd0);
    send_req(FN_REMOVE, 32'h0, 5'd31);
    send_req(FN_REMOVE, 32'h0, 5'd31);
  endtask

  // Every descriptor in use, then one more key, then empty it again.
  task automatic test_table_full();
    for (int i = 0; i < NPROC; i++) send_req(FN_BLOCK, 32'hA5A5_0000 + i, PidW'(i));
    send_req(FN_BLOCK, 32'h5A5A_5A5A, 5'd3);
    for (int i = NPROC - 1; i >= 0; i--) send_req(FN_UNBLOCK, 32'hA5A5_0000 + i, 5'd0);
    send_req(FN_PEEK, 32'hA5A5_0000, 5'd0);
  endtask

  task automatic send_random();
    logic [1:0]      fn;
    logic [KeyW-1:0] key;
    int              r;
    r = $urandom_range(0, 9);
    fn = (r < 4) ? FN_BLOCK : (r < 6) ? FN_UNBLOCK : (r < 8) ? FN_REMOVE : FN_PEEK;
    key = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, 7)];
    send_req(fn, key, PidW'($urandom_range(0, NPROC - 1)));
  endtask

  // Input keeps offering while the response side holds off.
  task automatic test_backpressure();
    hold_rsp = 1'b1;
    send_burst = 1'b1;
    repeat (20) send_random();
    send_burst = 1'b0;
    wait_drain();
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 50 == 0) send_burst = ($urandom_range(0, 3) == 0);
      send_random();
    end
    send_burst = 1'b0;
  endtask

  initial begin
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    hold_rsp = 1'b0;
    send_burst = 1'b0;
    n_errors = 0;
    for (int d = 0; d < NPROC; d++) begin
      sh_used[d] = 1'b0;
      sh_wait[d] = 1'b0;
    end
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int k = 2; k < 8; k++) key_pool[k] = $urandom();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_ops();
    test_table_full();
    wait_drain();
    test_backpressure();
    test_random_mix();
    wait_drain();

    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/swq_pkg.sv
rtl/core/swq_if.sv
rtl/core/swq_ram.sv
rtl/core/semaphore_wait_queue_table_core.sv
verif/tb.sv
